[hdl/byte_unstuffing_deframer_macros.svh]
// Assertion helpers for the deframer module.
`ifndef BYTE_UNSTUFFING_DEFRAMER_MACROS_SVH
`define BYTE_UNSTUFFING_DEFRAMER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BUD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BUD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bud_pkg.sv]
package bud_pkg;

   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 8'd1;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_END      = 2'd1,
      KIND_NO_START = 2'd2,
      KIND_BAD_ESC  = 2'd3
   } kind_type;

   typedef struct packed {
      logic in_frame;
      logic escape_armed;
   } frame_state_type;

   typedef struct packed {
      logic              emit;
      kind_type          kind;
      logic [BYTE_W-1:0] data;
   } step_result_type;

endpackage

[hdl/bud_decode.sv]
module bud_decode
   import bud_pkg::*;
(
   input  logic [BYTE_W-1:0] in_byte,
   input  logic [BYTE_W-1:0] flag_value,
   input  logic [BYTE_W-1:0] escape_value,
   input  frame_state_type   state,
   output frame_state_type   next_state,
   output step_result_type   result
);

   logic is_flag;
   logic is_esc;

   assign is_flag = (in_byte == flag_value);
   assign is_esc  = (in_byte == escape_value);

   // A byte equal to both values is treated as a flag, since the flag test wins.
   always_comb begin
      next_state  = state;
      result.emit = 1'b0;
      result.kind = KIND_DATA;
      result.data = '0;
      if (!state.in_frame) begin
         next_state.escape_armed = 1'b0;
         if (is_flag) begin
            next_state.in_frame = 1'b1;
         end else begin
            result.emit = 1'b1;
            result.kind = KIND_NO_START;
         end
      end else if (state.escape_armed) begin
         next_state.escape_armed = 1'b0;
         result.emit             = 1'b1;
         if (is_flag || is_esc) begin
            result.data = in_byte;
         end else begin
            next_state.in_frame = 1'b0;
            result.kind         = KIND_BAD_ESC;
         end
      end else if (is_flag) begin
         next_state.in_frame = 1'b0;
         result.emit         = 1'b1;
         result.kind         = KIND_END;
      end else if (is_esc) begin
         next_state.escape_armed = 1'b1;
      end else begin
         result.emit = 1'b1;
         result.data = in_byte;
      end
   end

endmodule

[hdl/byte_unstuffing_deframer.sv]
// Byte unstuffing deframer.
// The req channel (req_valid, req_stall, req_in_byte) carries the stuffed
// stream, one byte per item. The rsp channel (rsp_valid, rsp_stall, rsp_kind,
// rsp_data_byte) returns at most one item per byte: a data byte, a frame end,
// a missing opening flag or a bad escape. Opening flags and armed escape bytes
// produce no item. The csr channel writes the flag byte (index 0) and the
// escape byte (index 1); it is always ready and should only be used while the
// block is idle. Writes to other indexes are dropped.
// Each byte is captured in an input register and decoded by one level of
// compares. Its result is written into the output register when the byte
// advances, and it is offered on rsp from that register. With no
// stall, one byte is accepted in every cycle. While a result waits for the
// receiver, the input register still takes one more byte, and bytes that
// yield no item keep passing; req_stall rises only when the input register
// holds a byte whose result cannot move because the output register is
// still stalled.
// Synchronous reset empties both registers, restores flag 126 and escape 125,
// and returns the block to hunting for an opening flag.
`include "byte_unstuffing_deframer_macros.svh"

module byte_unstuffing_deframer
   import bud_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   // Configuration registers.
   logic [BYTE_W-1:0] flag_value_ff;
   logic [BYTE_W-1:0] flag_value_in;
   logic [BYTE_W-1:0] escape_value_ff;
   logic [BYTE_W-1:0] escape_value_in;

   // Input register.
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [BYTE_W-1:0] in_byte_in;

   // Framing state.
   frame_state_type   state_ff;
   frame_state_type   state_in;
   frame_state_type   step_state;
   step_result_type   step_result;

   // Output register.
   logic              out_valid_ff;
   logic              out_valid_in;
   kind_type          out_kind_ff;
   kind_type          out_kind_in;
   logic [BYTE_W-1:0] out_data_ff;
   logic [BYTE_W-1:0] out_data_in;

   logic out_free;
   logic advance;
   logic req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      flag_value_in   = flag_value_ff;
      escape_value_in = escape_value_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FLAG:   flag_value_in   = csr_data;
            CSR_ESCAPE: escape_value_in = csr_data;
            default:    ;
         endcase
      end
   end

   bud_decode u_decode (
      .in_byte      (in_byte_ff),
      .flag_value   (flag_value_ff),
      .escape_value (escape_value_ff),
      .state        (state_ff),
      .next_state   (step_state),
      .result       (step_result)
   );

   // The held byte moves on when its result has a free output slot, or when
   // it produces no result at all.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (out_free || !step_result.emit);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign state_in = advance ? step_state : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (advance && step_result.emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = step_result.kind;
         out_data_in  = step_result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_value_ff   <= FLAG_RESET;
         escape_value_ff <= ESCAPE_RESET;
         in_valid_ff     <= 1'b0;
         state_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         flag_value_ff   <= flag_value_in;
         escape_value_ff <= escape_value_in;
         in_valid_ff     <= in_valid_in;
         state_ff        <= state_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_data_byte = out_data_ff;

   // Control and error items always carry a zero data byte.
   `BUD_ASSERT(a_zero_data, clock, reset,
      out_valid_ff && (out_kind_ff != KIND_DATA) |-> (out_data_ff == '0),
      "non-data result carries a data byte")

   // Escape mode can only be armed inside a frame.
   `BUD_ASSERT_ALWAYS(a_armed_in_frame, clock,
      !state_ff.in_frame |-> !state_ff.escape_armed,
      "escape armed while hunting")

   // The input side only stalls while a byte is held.
   `BUD_ASSERT(a_stall_needs_byte, clock, reset,
      req_stall |-> in_valid_ff,
      "input stalled with an empty input register")

   // Leaving a frame always leaves a frame end or bad escape in the output.
   `BUD_ASSERT(a_leave_reports, clock, reset,
      $fell(state_ff.in_frame) && !$past(reset) |->
         out_valid_ff && ((out_kind_ff == KIND_END) || (out_kind_ff == KIND_BAD_ESC)),
      "frame left without a frame end or bad escape item")

endmodule
